// ===== sv/normalized_histogram_core_assert.svh =====
// assertion macros shared by the histogram rtl
// clocked implication checks, disabled while reset is high
`ifndef NORMALIZED_HISTOGRAM_CORE_ASSERT_SVH
`define NORMALIZED_HISTOGRAM_CORE_ASSERT_SVH

// same-cycle implication
`define NH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define NH_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== sv/nh_pkg.sv =====
// shared constants, codes and types of the normalized histogram
// no dependencies
`default_nettype none

package nh_pkg;

   localparam int BINS   = 1024;
   localparam int BIN_W  = $clog2(BINS);
   localparam int CNT_W  = 16;
   localparam int FRAC_W = 16;
   localparam int PROB_W = FRAC_W + 1;
   localparam int STEP_W = $clog2(FRAC_W);

   localparam logic [CNT_W-1:0]  HIST_MAX = {CNT_W{1'b1}};
   localparam logic [PROB_W-1:0] HIST_ONE = {1'b1, {FRAC_W{1'b0}}};

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] total;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROB_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== sv/nh_channel_if.sv =====
// request and response channel interfaces with valid/ready handshake
// depends on nh_pkg for field widths
`default_nettype none

interface nh_req_if
   import nh_pkg::*;
   ;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [15:0] sample_value;

   modport source (output valid, output opcode, output sample_value, input ready);
   modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

interface nh_rsp_if
   import nh_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [CNT_W-1:0]  bin_count;
   logic [PROB_W-1:0] probability;
   logic [1:0]        status;

   modport source (output valid, output bin_count, output probability, output status,
                   input ready);
   modport sink   (input valid, input bin_count, input probability, input status,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/normalized_histogram_core.sv =====
// normalized histogram: one transaction at a time through the bin memory and the divider
// add, or read with samples: memory read, update and divider load, 16 divider steps, quotient
// capture, output load; the next request is taken once the result has left the pending register
// read with no samples is answered from the read state; out of range, clear, unused opcode from idle
// synchronous reset, then a sweep through all BINS entries zeroes the bin memory, also after clear
// depends on nh_pkg, nh_channel_if, nh_divider and the assertion macro header
`default_nettype none

`include "normalized_histogram_core_assert.svh"

module normalized_histogram_core
   import nh_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   nh_req_if.sink   req_bus,
   nh_rsp_if.source rsp_bus
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_DIV   = 4'b1000
   } nh_state_type;

   logic [CNT_W-1:0] bin_mem [BINS];

   nh_state_type      state_ff, state_in;
   logic [BIN_W-1:0]  sweep_ff, sweep_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [1:0]        op_ff, op_in;
   logic [BIN_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  rd_data_ff;

   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  pend_cnt_ff, pend_cnt_in;
   logic [PROB_W-1:0] pend_prob_ff, pend_prob_in;
   logic [1:0]        pend_stat_ff, pend_stat_in;

   logic              out_vld_ff, out_vld_in;
   logic [CNT_W-1:0]  out_cnt_ff;
   logic [PROB_W-1:0] out_prob_ff;
   logic [1:0]        out_stat_ff;

   logic              accept;
   logic              in_range;
   logic              out_load;
   logic              wr_en;
   logic [BIN_W-1:0]  wr_addr;
   logic [CNT_W-1:0]  wr_data;
   logic [CNT_W-1:0]  cnt_new;
   logic [CNT_W-1:0]  total_new;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   nh_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_bus.ready = (state_ff == ST_IDLE) && !pend_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign in_range      = {1'b0, req_bus.sample_value} < (PROB_W)'(BINS);
   assign out_load      = pend_ff && (!out_vld_ff || rsp_bus.ready);

   always_comb begin
      cnt_new   = rd_data_ff;
      total_new = total_ff;
      if (op_ff == OP_ADD) begin
         if (rd_data_ff != HIST_MAX) cnt_new = rd_data_ff + 1'b1;
         if (total_ff != HIST_MAX) total_new = total_ff + 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      total_in     = total_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff && !out_load;
      pend_cnt_in  = pend_cnt_ff;
      pend_prob_in = pend_prob_ff;
      pend_stat_in = pend_stat_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = cnt_new;
      div_req      = '{start: 1'b0, count: cnt_new, total: total_new};

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == (BIN_W)'(BINS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_bus.opcode;
               idx_in = req_bus.sample_value[BIN_W-1:0];
               if ((req_bus.opcode == OP_ADD || req_bus.opcode == OP_READ) && in_range) begin
                  state_in = ST_READ;
               end else begin
                  pend_in      = 1'b1;
                  pend_cnt_in  = '0;
                  pend_prob_in = '0;
                  pend_stat_in = STATUS_OK;
                  if (req_bus.opcode == OP_ADD || req_bus.opcode == OP_READ) begin
                     pend_stat_in = STATUS_RANGE;
                  end else if (req_bus.opcode == OP_CLEAR) begin
                     total_in = '0;
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
               end
            end
         end
         ST_READ: begin
            cnt_in = cnt_new;
            if (op_ff == OP_ADD) begin
               wr_en    = 1'b1;
               total_in = total_new;
            end
            if (total_new == '0) begin
               pend_in      = 1'b1;
               pend_cnt_in  = rd_data_ff;
               pend_prob_in = '0;
               pend_stat_in = STATUS_EMPTY;
               state_in     = ST_IDLE;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               pend_in      = 1'b1;
               pend_cnt_in  = cnt_ff;
               pend_prob_in = div_rsp.quotient;
               pend_stat_in = STATUS_OK;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            sweep_in = '0;
         end
      endcase
   end

   assign out_vld_in = out_load || (out_vld_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         sweep_ff   <= '0;
         total_ff   <= '0;
         pend_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sweep_ff   <= sweep_in;
         total_ff   <= total_in;
         pend_ff    <= pend_in;
         out_vld_ff <= out_vld_in;
      end
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      pend_cnt_ff  <= pend_cnt_in;
      pend_prob_ff <= pend_prob_in;
      pend_stat_ff <= pend_stat_in;
      if (out_load) begin
         out_cnt_ff  <= pend_cnt_ff;
         out_prob_ff <= pend_prob_ff;
         out_stat_ff <= pend_stat_ff;
      end
   end

   // bin memory, one read and one write port
   always_ff @(posedge clock) begin
      rd_data_ff <= bin_mem[req_bus.sample_value[BIN_W-1:0]];
      if (wr_en) bin_mem[wr_addr] <= wr_data;
   end

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.bin_count   = out_cnt_ff;
   assign rsp_bus.probability = out_prob_ff;
   assign rsp_bus.status      = out_stat_ff;

   `NH_ASSERT_IMP(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `NH_ASSERT_IMP(a_div_total, clock, reset, state_ff == ST_DIV, total_ff != '0)
   `NH_ASSERT_IMP(a_sweep_total, clock, reset, state_ff == ST_CLEAR, total_ff == '0)
   `NH_ASSERT_NXT(a_load_valid, clock, reset, out_load, out_vld_ff)

endmodule

`default_nettype wire

// ===== sv/nh_divider.sv =====
// radix-2 restoring divider for floor(count * 65536 / total), count <= total
// depends on nh_pkg and the assertion macro header
`default_nettype none

`include "normalized_histogram_core_assert.svh"

module nh_divider
   import nh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output      div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic [PROB_W-1:0] quo_ff, quo_in;

   logic              top_ge;
   logic [CNT_W:0]    shifted;
   logic              step_ge;
   logic [CNT_W:0]    diff;

   always_comb begin
      top_ge  = div_req.count >= div_req.total;
      shifted = {rem_ff, 1'b0};
      step_ge = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = {STEP_W{1'b1}};
         den_in  = div_req.total;
         rem_in  = top_ge ? div_req.count - div_req.total : div_req.count;
         quo_in  = {{(PROB_W-1){1'b0}}, top_ge};
      end else if (busy_ff) begin
         rem_in  = step_ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in  = {quo_ff[PROB_W-2:0], step_ge};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   `NH_ASSERT_IMP(a_no_start_busy, clock, reset, div_req.start, !busy_ff)
   `NH_ASSERT_IMP(a_rem_below_den, clock, reset, busy_ff, rem_ff < den_ff)
   `NH_ASSERT_IMP(a_quo_bound, clock, reset, done_ff, quo_ff <= HIST_ONE)

endmodule

`default_nettype wire

// ===== verif/normalized_histogram_core_tb.sv =====
// testbench for normalized_histogram_core: directed and random add, read, clear and spare
// opcode traffic, each result checked against a bin-count predictor kept alongside the block
// depends on nh_pkg, nh_channel_if and the histogram rtl
`default_nettype none

module normalized_histogram_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nh_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int HEAVY_ADDS = 40;

   typedef struct packed {
      logic [CNT_W-1:0]  bin_count;
      logic [PROB_W-1:0] probability;
      logic [1:0]        status;
   } hist_result_type;

   logic clock = 1'b0;
   logic reset;

   nh_req_if req_bus ();
   nh_rsp_if rsp_bus ();

   normalized_histogram_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [CNT_W-1:0] bin_tally [BINS];
   logic [CNT_W-1:0] sample_total;
   hist_result_type  pending_results [$];
   int               error_count = 0;
   bit               sender_lazy = 1'b1;
   bit               receiver_lazy = 1'b1;
   int               receiver_hold = 0;
   int               hot_bins [8] = '{0, BINS-1, 1, 2, 511, 512, 700, 3};

   function automatic logic [PROB_W-1:0] share_of_total(input logic [CNT_W-1:0] count,
                                                         input logic [CNT_W-1:0] total);
      longint unsigned q;
      if (total == 0)
         return '0;
      q = {count, {FRAC_W{1'b0}}} / total;
      if (q > HIST_ONE)
         q = HIST_ONE;
      return q[PROB_W-1:0];
   endfunction

   function automatic hist_result_type apply_to_histogram(input logic [1:0] op,
                                                           input logic [15:0] val);
      hist_result_type r;
      int unsigned     slot;
      r = '0;
      if (op == OP_ADD || op == OP_READ) begin
         if (val >= BINS) begin
            r.status = STATUS_RANGE;
         end else begin
            slot = 32'(val);
            if (op == OP_ADD) begin
               if (bin_tally[slot] != HIST_MAX)
                  bin_tally[slot] = bin_tally[slot] + 1'b1;
               if (sample_total != HIST_MAX)
                  sample_total = sample_total + 1'b1;
               r.bin_count   = bin_tally[slot];
               r.probability = share_of_total(bin_tally[slot], sample_total);
            end else begin
               r.bin_count = bin_tally[slot];
               if (sample_total == 0)
                  r.status = STATUS_EMPTY;
               else
                  r.probability = share_of_total(bin_tally[slot], sample_total);
            end
         end
      end else if (op == OP_CLEAR) begin
         foreach (bin_tally[i])
            bin_tally[i] = '0;
         sample_total = '0;
      end
      return r;
   endfunction

   function automatic logic [15:0] pick_bin();
      if ($urandom_range(0, 9) < 6)
         return 16'(hot_bins[$urandom_range(0, 7)]);
      return 16'($urandom_range(0, BINS-1));
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [15:0] val);
      int gap;
      gap = sender_lazy ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= op;
      req_bus.sample_value <= val;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      pending_results.push_back(apply_to_histogram(op, val));
   endtask

   task automatic idle_until_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic compare_field(input string field, input logic [31:0] expected_v,
                                input logic [31:0] actual_v);
      if (actual_v !== expected_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, expected_v,
                  actual_v);
      end
   endtask

   // result checking
   always @(posedge clock) begin
      hist_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transaction, expected none actual %0d/%0d/%0d", $time,
                     rsp_bus.bin_count, rsp_bus.probability, rsp_bus.status);
         end else begin
            want = pending_results.pop_front();
            compare_field("bin_count", 32'(want.bin_count), 32'(rsp_bus.bin_count));
            compare_field("probability", 32'(want.probability), 32'(rsp_bus.probability));
            compare_field("status", 32'(want.status), 32'(rsp_bus.status));
         end
      end
   end

   // result side stalls
   initial begin
      int n;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (receiver_hold > 0) begin
            n = receiver_hold;
            receiver_hold = 0;
         end else begin
            n = receiver_lazy ? $urandom_range(0, 7) : 0;
         end
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do
            @(posedge clock);
         while (rsp_bus.valid !== 1'b1);
      end
   end

   task automatic test_empty_and_range();
      send_item(OP_READ, 16'd0);
      send_item(OP_READ, 16'(BINS-1));
      send_item(OP_READ, 16'hFFFF);
      send_item(OP_ADD, 16'hFFFF);
      send_item(OP_ADD, 16'(BINS));
      send_item(OP_SPARE, 16'hFFFF);
      send_item(OP_CLEAR, 16'd0);
   endtask

   task automatic test_add_read_clear();
      send_item(OP_ADD, 16'd0);
      send_item(OP_ADD, 16'd0);
      send_item(OP_ADD, 16'(BINS-1));
      send_item(OP_READ, 16'd0);
      send_item(OP_READ, 16'(BINS-1));
      send_item(OP_READ, 16'd5);
      send_item(OP_READ, 16'h5555);
      send_item(OP_ADD, 16'h02AA);
      send_item(OP_SPARE, 16'd0);
      send_item(OP_CLEAR, 16'hFFFF);
      send_item(OP_READ, 16'd0);
      send_item(OP_ADD, 16'd1);
      send_item(OP_READ, 16'd1);
   endtask

   task automatic test_random_traffic(input int n_items);
      int          roll;
      logic [1:0]  op;
      logic [15:0] val;
      for (int i = 0; i < n_items; i++) begin
         if (i % 150 == 0) begin
            sender_lazy   = 1'($urandom_range(0, 1));
            receiver_lazy = 1'($urandom_range(0, 1));
         end
         roll = $urandom_range(0, 199);
         if (roll < 110) begin
            op  = OP_ADD;
            val = pick_bin();
         end else if (roll < 170) begin
            op  = OP_READ;
            val = pick_bin();
         end else if (roll < 185) begin
            op  = $urandom_range(0, 1) ? OP_ADD : OP_READ;
            val = 16'($urandom_range(BINS, 65535));
         end else if (roll < 188) begin
            op  = OP_CLEAR;
            val = 16'($urandom_range(0, 65535));
         end else begin
            op  = OP_SPARE;
            val = 16'($urandom_range(0, 65535));
         end
         send_item(op, val);
      end
      sender_lazy   = 1'b1;
      receiver_lazy = 1'b1;
   endtask

   // result side held off while requests keep coming
   task automatic test_output_stall();
      idle_until_drained();
      sender_lazy   = 1'b0;
      receiver_hold = 300;
      for (int i = 0; i < 16; i++)
         send_item(i % 3 == 0 ? OP_ADD : OP_READ, pick_bin());
      sender_lazy = 1'b1;
   endtask

   task automatic test_sender_pause();
      for (int i = 0; i < 6; i++)
         send_item(OP_ADD, pick_bin());
      idle_until_drained();
      for (int i = 0; i < 6; i++)
         send_item(OP_READ, pick_bin());
   endtask

   // one bin holding nearly the whole total after a clear
   task automatic test_heavy_bin();
      idle_until_drained();
      sender_lazy   = 1'b0;
      receiver_lazy = 1'b0;
      send_item(OP_CLEAR, 16'd0);
      for (int i = 0; i < HEAVY_ADDS; i++)
         send_item(OP_ADD, 16'd7);
      send_item(OP_ADD, 16'd8);
      send_item(OP_READ, 16'd7);
      send_item(OP_READ, 16'd8);
      send_item(OP_READ, 16'd9);
      sender_lazy   = 1'b1;
      receiver_lazy = 1'b1;
   endtask

   initial begin
      foreach (bin_tally[i])
         bin_tally[i] = '0;
      sample_total = '0;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.opcode       <= OP_ADD;
      req_bus.sample_value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_range();
      test_add_read_clear();
      test_random_traffic(1800);
      test_output_stall();
      test_sender_pause();
      test_heavy_bin();
      idle_until_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/nh_pkg.sv
sv/nh_channel_if.sv
sv/nh_divider.sv
sv/normalized_histogram_core.sv
verif/normalized_histogram_core_tb.sv
